// ===== src/lfubcd_pkg.sv =====
// shared constants, types and compare-unit result for the lfu block cache directory
package lfubcd_pkg;

  localparam int ENTRIES           = 64;
  localparam int FILE_ID_BITS      = 16;
  localparam int BLOCK_NUMBER_BITS = 32;
  localparam int COUNT_BITS        = 16;

  localparam int IDX_BITS         = $clog2(ENTRIES);
  localparam int FILL_BITS        = $clog2(ENTRIES + 1);
  localparam int ENTRY_INDEX_BITS = 6;
  localparam int FUNC_BITS        = 2;

  localparam logic [FUNC_BITS-1:0] FUNC_READ  = 2'd0;
  localparam logic [FUNC_BITS-1:0] FUNC_WRITE = 2'd1;
  localparam logic [FUNC_BITS-1:0] FUNC_FLUSH = 2'd2;
  localparam logic [FUNC_BITS-1:0] FUNC_NONE  = 2'd3;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX  = {COUNT_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] COUNT_FILL = COUNT_BITS'(2);

  typedef struct packed {
    logic [COUNT_BITS-1:0]        count;
    logic [BLOCK_NUMBER_BITS-1:0] block;
    logic [FILE_ID_BITS-1:0]      file;
  } entry_t;

  localparam int ENTRY_BITS = $bits(entry_t);

  typedef struct packed {
    logic file_match;
    logic tag_match;
    logic count_less;
  } cmp_res_t;

endpackage

// ===== src/lfubcd_ram.sv =====
// generic simple dual-port ram with registered read
module lfubcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/lfubcd_cmp.sv =====
// shared compare unit: tag match, file match and lowest-count test for one entry
module lfubcd_cmp (
  input  lfubcd_pkg::entry_t                          entry,
  input  logic [lfubcd_pkg::FILE_ID_BITS-1:0]         key_file,
  input  logic [lfubcd_pkg::BLOCK_NUMBER_BITS-1:0]    key_block,
  input  logic [lfubcd_pkg::COUNT_BITS-1:0]           min_count,
  output lfubcd_pkg::cmp_res_t                        res
);

  always_comb begin
    res.file_match = (entry.file == key_file);
    res.tag_match  = (entry.file == key_file) && (entry.block == key_block);
    res.count_less = (entry.count < min_count);
  end

endmodule

// ===== src/lfu_block_cache_directory_unit.sv =====
// top level: lfu block cache directory with scan sequencer and output register
//
// Fully associative write-back block directory with least-frequently-used
// replacement. Each input transaction is a read access, a write access or a
// flush of one file's dirty blocks; the block takes one transaction at a time
// and drops s_tready while it works. Directory tags and use counts live in a
// single ram whose one read port is scanned one entry per cycle, save while a
// flush result waits on m_tready, through one shared compare unit, over the
// filled entries only. An access scan ends early on a hit, and m_tready can
// hold any result back. An access gives one
// result; a flush gives one result per dirty block of the file in ascending
// entry order, or one acknowledge when none is dirty, with m_tlast on the
// final one. Func code three is taken and ignored. There is no clearing pass
// after reset: the fill count marks which entries hold data.
module lfu_block_cache_directory_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // file_id [15:0], block_number [47:16]
  input  logic [1:0]  s_tuser,   // func [1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // entry_index [5:0], writeback_file [21:6],
                                 // writeback_block [53:22], zero [55:54]
  output logic [1:0]  m_tuser,   // hit [0], writeback_valid [1]
  output logic        m_tlast
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_WRITE = 2'd2;
  localparam logic [1:0] S_FEND  = 2'd3;

  localparam int IW = lfubcd_pkg::IDX_BITS;
  localparam int FW = lfubcd_pkg::FILL_BITS;
  localparam int KW = lfubcd_pkg::FILE_ID_BITS;
  localparam int BW = lfubcd_pkg::BLOCK_NUMBER_BITS;
  localparam int CW = lfubcd_pkg::COUNT_BITS;
  localparam int XW = lfubcd_pkg::ENTRY_INDEX_BITS;

  logic [1:0]                          state;
  logic [FW-1:0]                       fill_count;
  logic [lfubcd_pkg::ENTRIES-1:0]      dirty;
  logic [lfubcd_pkg::FUNC_BITS-1:0]    op_func;
  logic [KW-1:0]                       op_file;
  logic [BW-1:0]                       op_block;
  logic [FW-1:0]                       rd_idx;
  logic                                cmp_valid;
  logic [IW-1:0]                       cmp_idx;
  logic                                found;
  logic [IW-1:0]                       hit_idx;
  logic [CW-1:0]                       hit_count;
  logic                                have_min;
  logic [CW-1:0]                       min_count;
  logic [IW-1:0]                       min_idx;
  logic [KW-1:0]                       min_file;
  logic [BW-1:0]                       min_block;
  logic                                pend_valid;
  logic [IW-1:0]                       pend_idx;
  logic [BW-1:0]                       pend_block;

  logic                                out_hit;
  logic [XW-1:0]                       out_idx;
  logic                                out_wbv;
  logic [KW-1:0]                       out_file;
  logic [BW-1:0]                       out_block;
  logic                                out_last;

  lfubcd_pkg::entry_t                  rdata;
  lfubcd_pkg::entry_t                  wdata;
  lfubcd_pkg::cmp_res_t                res;
  logic                                we;
  logic [IW-1:0]                       waddr;
  logic                                re;
  logic                                out_free;
  logic                                rd_ok;
  logic                                is_flush;
  logic                                flush_hit;
  logic                                stall;
  logic                                adv;
  logic                                full;
  logic [IW-1:0]                       slot;
  logic [CW-1:0]                       hit_count_next;
  logic                                s_fire;

  lfubcd_ram #(
    .WIDTH(lfubcd_pkg::ENTRY_BITS),
    .DEPTH(lfubcd_pkg::ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(rd_idx[IW-1:0]),
    .rdata(rdata)
  );

  lfubcd_cmp u_cmp (
    .entry    (rdata),
    .key_file (op_file),
    .key_block(op_block),
    .min_count(min_count),
    .res      (res)
  );

  always_comb begin
    s_tready  = (state == S_IDLE);
    s_fire    = s_tvalid && s_tready;
    out_free  = !m_tvalid || m_tready;
    rd_ok     = (rd_idx < fill_count);
    is_flush  = (op_func == lfubcd_pkg::FUNC_FLUSH);
    flush_hit = cmp_valid && is_flush && res.file_match && dirty[cmp_idx];
    stall     = flush_hit && pend_valid && !out_free;
    adv       = (state == S_SCAN) && !stall;
    re        = adv && rd_ok;
    full      = (fill_count == FW'(lfubcd_pkg::ENTRIES));
    slot      = full ? min_idx : fill_count[IW-1:0];
    hit_count_next = (hit_count == lfubcd_pkg::COUNT_MAX) ? hit_count : hit_count + 1'b1;
    we        = (state == S_WRITE) && out_free;
    waddr     = found ? hit_idx : slot;
    wdata.file  = op_file;
    wdata.block = op_block;
    wdata.count = found ? hit_count_next : lfubcd_pkg::COUNT_FILL;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fill_count <= '0;
      dirty      <= '0;
      rd_idx     <= '0;
      cmp_valid  <= 1'b0;
      found      <= 1'b0;
      have_min   <= 1'b0;
      pend_valid <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_fire) begin
            op_func    <= s_tuser;
            op_file    <= s_tdata[KW-1:0];
            op_block   <= s_tdata[KW+BW-1:KW];
            rd_idx     <= '0;
            cmp_valid  <= 1'b0;
            found      <= 1'b0;
            have_min   <= 1'b0;
            pend_valid <= 1'b0;
            if (s_tuser != lfubcd_pkg::FUNC_NONE) begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (adv) begin
            cmp_valid <= rd_ok;
            cmp_idx   <= rd_idx[IW-1:0];
            if (rd_ok) begin
              rd_idx <= rd_idx + 1'b1;
            end
            if (cmp_valid && !is_flush) begin
              if (res.tag_match) begin
                found     <= 1'b1;
                hit_idx   <= cmp_idx;
                hit_count <= rdata.count;
                state     <= S_WRITE;
              end else if (!have_min || res.count_less) begin
                have_min  <= 1'b1;
                min_count <= rdata.count;
                min_idx   <= cmp_idx;
                min_file  <= rdata.file;
                min_block <= rdata.block;
              end
            end
            if (flush_hit) begin
              dirty[cmp_idx] <= 1'b0;
              pend_valid     <= 1'b1;
              pend_idx       <= cmp_idx;
              pend_block     <= rdata.block;
              if (pend_valid) begin
                m_tvalid  <= 1'b1;
                out_hit   <= 1'b0;
                out_idx   <= XW'(pend_idx);
                out_wbv   <= 1'b1;
                out_file  <= op_file;
                out_block <= pend_block;
                out_last  <= 1'b0;
              end
            end
            if (!rd_ok && !cmp_valid) begin
              state <= is_flush ? S_FEND : S_WRITE;
            end
          end
        end
        S_WRITE: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            out_last <= 1'b1;
            if (found) begin
              if (op_func == lfubcd_pkg::FUNC_WRITE) begin
                dirty[hit_idx] <= 1'b1;
              end
              out_hit   <= 1'b1;
              out_idx   <= XW'(hit_idx);
              out_wbv   <= 1'b0;
              out_file  <= '0;
              out_block <= '0;
            end else begin
              dirty[slot] <= (op_func == lfubcd_pkg::FUNC_WRITE);
              if (!full) begin
                fill_count <= fill_count + 1'b1;
              end
              out_hit <= 1'b0;
              out_idx <= XW'(slot);
              if (full && dirty[slot]) begin
                out_wbv   <= 1'b1;
                out_file  <= min_file;
                out_block <= min_block;
              end else begin
                out_wbv   <= 1'b0;
                out_file  <= '0;
                out_block <= '0;
              end
            end
            state <= S_IDLE;
          end
        end
        S_FEND: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            out_hit  <= 1'b0;
            out_last <= 1'b1;
            if (pend_valid) begin
              out_idx   <= XW'(pend_idx);
              out_wbv   <= 1'b1;
              out_file  <= op_file;
              out_block <= pend_block;
            end else begin
              out_idx   <= '0;
              out_wbv   <= 1'b0;
              out_file  <= '0;
              out_block <= '0;
            end
            pend_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign m_tdata = {2'b00, out_block, out_file, out_idx};
  assign m_tuser = {out_wbv, out_hit};
  assign m_tlast = out_last;

endmodule

// ===== src/lfubcd_checker.sv =====
// port-level assertions for the lfu block cache directory, bound to the top level
module lfubcd_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [55:0] m_tdata,
  input logic [1:0]  m_tuser,
  input logic        m_tlast
);

  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result shown right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("stalled result transaction changed");

  a_hit_alone: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tlast && !m_tuser[1])
    else $error("hit result with writeback or not last");

  a_no_wb_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[1] |-> m_tdata[55:6] == 50'd0)
    else $error("writeback fields set without writeback");

  a_mid_flush: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> m_tuser[1] && !m_tuser[0])
    else $error("non-final result is not a flush writeback");

endmodule

bind lfu_block_cache_directory_unit lfubcd_checker u_lfubcd_checker (
  .clk     (clk),
  .rst     (rst),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tuser (m_tuser),
  .m_tlast (m_tlast)
);
